// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PTIM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define PTIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ptim_pkg.sv
// shared constants and types of the pyramid tile index mapper
`default_nettype none

package ptim_pkg;

    localparam int MAX_LEVELS_DEF = 32;
    localparam int AXIS_BITS_DEF  = 16;

    localparam int PIX_W      = 16;         // level and tile sizes in pixels
    localparam int DIV_W      = PIX_W + 1;  // rounded-up dividend
    localparam int SEL_W      = 5;
    localparam int TILE_W     = 32;
    localparam int LCNT_W     = 6;
    localparam int LVL_OUT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd2;

    localparam logic [PIX_W-1:0]  TILE_SIZE_RESET   = 16'd16;
    localparam logic [LCNT_W-1:0] LEVEL_COUNT_RESET = 6'd0;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // control of one entry into the level walk
    typedef struct packed {
        logic valid;
        logic load;
    } ptim_ctl_t;

    // status of one finished query
    typedef struct packed {
        logic valid;
        logic oor;
    } ptim_res_t;

endpackage

`default_nettype wire

// File: rtl/ptim_if.sv
// channel interfaces: request and response with valid / ready
`default_nettype none

interface ptim_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  level_select;
    logic [15:0] level_width;
    logic [15:0] level_height;
    logic [31:0] linear_tile;

    modport source (output valid, command, level_select, level_width, level_height,
                    linear_tile, input ready);
    modport sink   (input valid, command, level_select, level_width, level_height,
                    linear_tile, output ready);
endinterface

interface ptim_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  level_found;
    logic [15:0] tile_column;
    logic [15:0] tile_row;
    logic        out_of_range;

    modport source (output valid, level_found, tile_column, tile_row, out_of_range,
                    input ready);
    modport sink   (input valid, level_found, tile_column, tile_row, out_of_range,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/ptim_walk.sv
// level table, one walk stage per level, and row / column divider stages
`default_nettype none

module ptim_walk #(
    parameter int MAX_LEVELS = ptim_pkg::MAX_LEVELS_DEF,
    parameter int AXIS_BITS  = ptim_pkg::AXIS_BITS_DEF,
    parameter int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              adv,
    input  wire ptim_pkg::ptim_ctl_t               ent,
    input  wire logic [ptim_pkg::SEL_W-1:0]        ent_sel,
    input  wire logic [AXIS_BITS-1:0]              ent_cols,
    input  wire logic [AXIS_BITS-1:0]              ent_rows,
    input  wire logic [ptim_pkg::TILE_W-1:0]       ent_tile,
    input  wire logic [ptim_pkg::LCNT_W-1:0]       level_count,
    output logic                                   busy,
    output ptim_pkg::ptim_res_t                    res,
    output logic [LVL_W-1:0]                       res_lvl,
    output logic [AXIS_BITS-1:0]                   res_col,
    output logic [AXIS_BITS-1:0]                   res_row
);

    localparam int L  = MAX_LEVELS;
    localparam int A  = AXIS_BITS;
    localparam int PW = 2 * AXIS_BITS;
    localparam int TW = ptim_pkg::TILE_W;
    localparam int CW = ptim_pkg::LCNT_W + 1;

    logic [A-1:0]  cols_tbl [0:L-1];
    logic [PW-1:0] area_tbl [0:L-1];
    logic [PW-1:0] area_new;
    logic          tbl_we;

    assign tbl_we   = adv && ent.valid && (ent.load == ptim_pkg::CMD_LOAD);
    assign area_new = PW'(ent_cols) * PW'(ent_rows);

    // walk stage registers
    logic [L-1:0]   wv_reg;
    logic [L:0]     wv_chain;
    logic           wf_reg   [0:L-1];
    logic [LVL_W-1:0] wlvl_reg [0:L-1];
    logic [TW-1:0]  wrem_reg [0:L-1];
    logic [A-1:0]   wcols_reg [0:L-1];

    assign wv_chain = {wv_reg, ent.valid && (ent.load == ptim_pkg::CMD_QUERY)};

    // divider stage registers
    logic [A-1:0]   dv_reg;
    logic [A:0]     dv_chain;
    logic           df_reg   [0:A-1];
    logic [LVL_W-1:0] dlvl_reg [0:A-1];
    logic [A-1:0]   dr_reg   [0:A-1];
    logic [A-1:0]   dlow_reg [0:A-1];
    logic [A-1:0]   dq_reg   [0:A-1];
    logic [A-1:0]   dcols_reg [0:A-1];

    assign dv_chain = {dv_reg, wv_reg[L-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
            dv_reg <= '0;
        end
        else if (adv)
        begin
            wv_reg <= wv_chain[L-1:0];
            dv_reg <= dv_chain[A-1:0];
        end
    end

    genvar l, j;
    generate
        for (l = 0; l < L; l++)
        begin : g_lvl
            localparam logic [CW-1:0] LIDX = CW'(l);
            logic             in_f;
            logic [LVL_W-1:0] in_lvl;
            logic [TW-1:0]    in_rem;
            logic [A-1:0]     in_cols;
            logic [TW-1:0]    area32;
            logic             act;
            logic             hit;

            if (l == 0)
            begin : g_first
                assign in_f    = 1'b0;
                assign in_lvl  = '0;
                assign in_rem  = ent_tile;
                assign in_cols = '0;
            end
            else
            begin : g_rest
                assign in_f    = wf_reg[l-1];
                assign in_lvl  = wlvl_reg[l-1];
                assign in_rem  = wrem_reg[l-1];
                assign in_cols = wcols_reg[l-1];
            end

            assign area32 = TW'(area_tbl[l]);
            assign act    = LIDX < {1'b0, level_count};
            // an empty level never hits and subtracts nothing
            assign hit    = act && !in_f && (in_rem < area32);

            always_ff @(posedge clk)
            begin
                if (tbl_we && (CW'(ent_sel) == LIDX))
                begin
                    cols_tbl[l] <= ent_cols;
                    area_tbl[l] <= area_new;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    wf_reg[l]    <= in_f || hit;
                    wlvl_reg[l]  <= hit ? LVL_W'(l) : in_lvl;
                    wrem_reg[l]  <= (act && !in_f && !hit) ? in_rem - area32 : in_rem;
                    wcols_reg[l] <= hit ? cols_tbl[l] : in_cols;
                end
            end
        end

        for (j = 0; j < A; j++)
        begin : g_div
            logic             in_f;
            logic [LVL_W-1:0] in_lvl;
            logic [A-1:0]     in_r;
            logic [A-1:0]     in_low;
            logic [A-1:0]     in_q;
            logic [A-1:0]     in_cols;
            logic [A:0]       tmp;
            logic [A:0]       diff;
            logic             ge;

            if (j == 0)
            begin : g_first
                assign in_f    = wf_reg[L-1];
                assign in_lvl  = wlvl_reg[L-1];
                assign in_r    = wrem_reg[L-1][PW-1:A];
                assign in_low  = wrem_reg[L-1][A-1:0];
                assign in_q    = '0;
                assign in_cols = wcols_reg[L-1];
            end
            else
            begin : g_rest
                assign in_f    = df_reg[j-1];
                assign in_lvl  = dlvl_reg[j-1];
                assign in_r    = dr_reg[j-1];
                assign in_low  = dlow_reg[j-1];
                assign in_q    = dq_reg[j-1];
                assign in_cols = dcols_reg[j-1];
            end

            assign tmp  = {in_r, in_low[A-1]};
            assign diff = tmp - {1'b0, in_cols};
            assign ge   = tmp >= {1'b0, in_cols};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    df_reg[j]    <= in_f;
                    dlvl_reg[j]  <= in_lvl;
                    dr_reg[j]    <= ge ? diff[A-1:0] : tmp[A-1:0];
                    dlow_reg[j]  <= {in_low[A-2:0], 1'b0};
                    dq_reg[j]    <= {in_q[A-2:0], ge};
                    dcols_reg[j] <= in_cols;
                end
            end
        end
    endgenerate

    assign busy      = |wv_reg;
    assign res.valid = dv_reg[A-1];
    assign res.oor   = !df_reg[A-1];
    assign res_lvl   = dlvl_reg[A-1];
    assign res_col   = dr_reg[A-1];
    assign res_row   = dq_reg[A-1];

endmodule

`default_nettype wire

// File: rtl/pyramid_tile_index_mapper_unit.sv
// top level of the pyramid tile index mapper
//
//  channel | dir | carries                                          | per transaction
//  req     | in  | command, level_select, level_width/height, tile  | one load or query
//  rsp     | out | level_found, tile_column, tile_row, out_of_range | one result per query
//  cfg     | in  | cfg_we, cfg_index, cfg_data                      | one register write
//
// one transaction per cycle enters unless a stalled rsp or a waiting load holds the front;
// rsp.valid for a query rises after the front, walk and divider stages and the result register
// after a capture stage, 17 front stages divide load sizes by the tile, one quotient bit each
// a load waits at the table port while queries are in the level walk
// reset clears valid bits, presets config registers; level table holds garbage until loaded
// a stalled rsp freezes every stage, so nothing is dropped or repeated
`default_nettype none
`include "assert_macros.svh"

module pyramid_tile_index_mapper_unit #(
    parameter int MAX_LEVELS = ptim_pkg::MAX_LEVELS_DEF,
    parameter int AXIS_BITS  = ptim_pkg::AXIS_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ptim_req_if.sink                                 req,
    ptim_rsp_if.source                               rsp,
    input  wire logic                                cfg_we,
    input  wire logic [ptim_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ptim_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int A     = AXIS_BITS;
    localparam int NF    = ptim_pkg::DIV_W;
    localparam int PX    = ptim_pkg::PIX_W;
    localparam int TW    = ptim_pkg::TILE_W;
    localparam int SW    = ptim_pkg::SEL_W;
    localparam int OLW   = ptim_pkg::LVL_OUT_W;
    localparam int LCW   = ptim_pkg::LCNT_W;
    localparam logic [NF-1:0] AXIS_MASK = NF'((2 ** A) - 1);

    // config registers
    logic [PX-1:0]  tw_reg;
    logic [PX-1:0]  th_reg;
    logic [LCW-1:0] lc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg <= ptim_pkg::TILE_SIZE_RESET;
            th_reg <= ptim_pkg::TILE_SIZE_RESET;
            lc_reg <= ptim_pkg::LEVEL_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptim_pkg::REG_TILE_WIDTH:  tw_reg <= cfg_data;
                ptim_pkg::REG_TILE_HEIGHT: th_reg <= cfg_data;
                ptim_pkg::REG_LEVEL_COUNT: lc_reg <= cfg_data[LCW-1:0];
                default: ;
            endcase
        end
    end

    // zero tile size acts as one
    logic [PX-1:0] tw_eff;
    logic [PX-1:0] th_eff;
    assign tw_eff = (tw_reg == '0) ? PX'(1) : tw_reg;
    assign th_eff = (th_reg == '0) ? PX'(1) : th_reg;

    // stage advance: everything moves unless the result is stuck; block also holds the front
    logic adv;
    logic fadv;
    logic block;
    logic walk_busy;
    logic ov_reg;

    assign adv  = !ov_reg || rsp.ready;
    assign fadv = adv && !block;
    assign req.ready = fadv;

    // front pipeline: stage 0 captures, stages 1..NF divide one bit each
    logic [NF:0]   fv_reg;
    logic [NF:0]   fv_chain;
    logic          fload_reg [0:NF];
    logic [SW-1:0] fsel_reg  [0:NF];
    logic [TW-1:0] ftile_reg [0:NF];
    logic [NF-1:0] fnw_reg   [0:NF];
    logic [NF-1:0] fnh_reg   [0:NF];
    logic [PX-1:0] frw_reg   [0:NF];
    logic [PX-1:0] frh_reg   [0:NF];
    logic [NF-1:0] fqw_reg   [0:NF];
    logic [NF-1:0] fqh_reg   [0:NF];

    assign fv_chain = {fv_reg[NF-1:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (fadv)
            fv_reg <= fv_chain;
    end

    // ceil(size / tile) as floor((size + tile - 1) / tile)
    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            fload_reg[0] <= (req.command == ptim_pkg::CMD_LOAD);
            fsel_reg[0]  <= req.level_select;
            ftile_reg[0] <= req.linear_tile;
            fnw_reg[0]   <= NF'(req.level_width) + NF'(tw_eff) - NF'(1);
            fnh_reg[0]   <= NF'(req.level_height) + NF'(th_eff) - NF'(1);
            frw_reg[0]   <= '0;
            frh_reg[0]   <= '0;
            fqw_reg[0]   <= '0;
            fqh_reg[0]   <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NF; k++)
        begin : g_front
            localparam int B = NF - 1 - k;
            logic [NF-1:0] tmp_w;
            logic [NF-1:0] tmp_h;
            logic [NF-1:0] dif_w;
            logic [NF-1:0] dif_h;
            logic          ge_w;
            logic          ge_h;

            assign tmp_w = {frw_reg[k], fnw_reg[k][B]};
            assign tmp_h = {frh_reg[k], fnh_reg[k][B]};
            assign ge_w  = tmp_w >= NF'(tw_eff);
            assign ge_h  = tmp_h >= NF'(th_eff);
            assign dif_w = tmp_w - NF'(tw_eff);
            assign dif_h = tmp_h - NF'(th_eff);

            always_ff @(posedge clk)
            begin
                if (fadv)
                begin
                    fload_reg[k+1] <= fload_reg[k];
                    fsel_reg[k+1]  <= fsel_reg[k];
                    ftile_reg[k+1] <= ftile_reg[k];
                    fnw_reg[k+1]   <= fnw_reg[k];
                    fnh_reg[k+1]   <= fnh_reg[k];
                    frw_reg[k+1]   <= ge_w ? dif_w[PX-1:0] : tmp_w[PX-1:0];
                    frh_reg[k+1]   <= ge_h ? dif_h[PX-1:0] : tmp_h[PX-1:0];
                    fqw_reg[k+1]   <= fqw_reg[k] | (ge_w ? (NF'(1) << B) : '0);
                    fqh_reg[k+1]   <= fqh_reg[k] | (ge_h ? (NF'(1) << B) : '0);
                end
            end
        end
    endgenerate

    // saturate per-axis counts
    logic [A-1:0] ent_cols;
    logic [A-1:0] ent_rows;
    assign ent_cols = (fqw_reg[NF] > AXIS_MASK) ? AXIS_MASK[A-1:0] : fqw_reg[NF][A-1:0];
    assign ent_rows = (fqh_reg[NF] > AXIS_MASK) ? AXIS_MASK[A-1:0] : fqh_reg[NF][A-1:0];

    // a load may not change the table under queries still walking it
    assign block = fv_reg[NF] && fload_reg[NF] && walk_busy;

    ptim_pkg::ptim_ctl_t ent;
    assign ent.valid = fv_reg[NF] && !block;
    assign ent.load  = fload_reg[NF] ? ptim_pkg::CMD_LOAD : ptim_pkg::CMD_QUERY;

    ptim_pkg::ptim_res_t res;
    logic [LVL_W-1:0]    res_lvl;
    logic [A-1:0]        res_col;
    logic [A-1:0]        res_row;

    ptim_walk #(
        .MAX_LEVELS (MAX_LEVELS),
        .AXIS_BITS  (AXIS_BITS),
        .LVL_W      (LVL_W)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .ent         (ent),
        .ent_sel     (fsel_reg[NF]),
        .ent_cols    (ent_cols),
        .ent_rows    (ent_rows),
        .ent_tile    (ftile_reg[NF]),
        .level_count (lc_reg),
        .busy        (walk_busy),
        .res         (res),
        .res_lvl     (res_lvl),
        .res_col     (res_col),
        .res_row     (res_row)
    );

    // result register; out of range zeroes the position fields
    logic [OLW-1:0] olvl_reg;
    logic [PX-1:0]  ocol_reg;
    logic [PX-1:0]  orow_reg;
    logic           ooor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ooor_reg <= res.oor;
            olvl_reg <= res.oor ? '0 : OLW'(res_lvl);
            ocol_reg <= res.oor ? '0 : PX'(res_col);
            orow_reg <= res.oor ? '0 : PX'(res_row);
        end
    end

    assign rsp.valid        = ov_reg;
    assign rsp.level_found  = olvl_reg;
    assign rsp.tile_column  = ocol_reg;
    assign rsp.tile_row     = orow_reg;
    assign rsp.out_of_range = ooor_reg;

    // a stuck result must hold off new requests
    `PTIM_ASSERT_IMPLY(a_stall_blocks_req, rsp.valid && !rsp.ready, !req.ready)
    // a stuck result freezes the front pipeline
    `PTIM_ASSERT_NEXT(a_stall_holds_front, rsp.valid && !rsp.ready, $stable(fv_reg))
    // a load facing a busy walk holds off new requests
    `PTIM_ASSERT_IMPLY(a_load_waits, fv_reg[NF] && fload_reg[NF] && walk_busy, !req.ready)

endmodule

`default_nettype wire

// File: test/tb_top.sv
// testbench of the pyramid tile index mapper: loads, queries and register settings
`timescale 1ns / 100ps
`default_nettype none

module tb_top;

    typedef struct {
        logic [4:0]  level_found;
        logic [15:0] tile_column;
        logic [15:0] tile_row;
        logic        out_of_range;
    } tile_pos_t;

    // predictor of the level table and the level walk, plus the queue of expected positions
    class tile_map_scoreboard;
        logic [15:0] tile_w = ptim_pkg::TILE_SIZE_RESET;
        logic [15:0] tile_h = ptim_pkg::TILE_SIZE_RESET;
        logic [5:0]  levels = ptim_pkg::LEVEL_COUNT_RESET;
        logic [15:0] cols_of [32];
        logic [15:0] rows_of [32];
        tile_pos_t   expected_pos [$];
        int          errors = 0;

        function void write_reg(logic [ptim_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                ptim_pkg::REG_TILE_WIDTH:  tile_w = data;
                ptim_pkg::REG_TILE_HEIGHT: tile_h = data;
                ptim_pkg::REG_LEVEL_COUNT: levels = data[5:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] tiles_along(logic [15:0] pixels, logic [15:0] tile);
            longint t;
            longint n;
            t = (tile == 0) ? 1 : longint'(tile);
            n = (longint'(pixels) + t - 1) / t;
            return (n > 16'hFFFF) ? 16'hFFFF : n[15:0];
        endfunction

        function int walk_levels();
            return (levels > 32) ? 32 : int'(levels);
        endfunction

        function longint total_tiles();
            longint sum;
            sum = 0;
            for (int l = 0; l < walk_levels(); l++)
                sum += longint'(cols_of[l]) * longint'(rows_of[l]);
            return sum;
        endfunction

        // one accepted request: a load updates the table, a query yields one position
        function void note_input(logic cmd, logic [4:0] sel, logic [15:0] w, logic [15:0] h,
                                 logic [31:0] tile);
            longint    rem;
            longint    area;
            longint    row;
            tile_pos_t pos;
            if (cmd == ptim_pkg::CMD_LOAD)
            begin
                cols_of[sel] = tiles_along(w, tile_w);
                rows_of[sel] = tiles_along(h, tile_h);
                return;
            end
            rem = longint'(tile);
            pos = '{5'd0, 16'd0, 16'd0, 1'b1};
            for (int l = 0; l < walk_levels(); l++)
            begin
                area = longint'(cols_of[l]) * longint'(rows_of[l]);
                if (rem < area)
                begin
                    row = rem / longint'(cols_of[l]);
                    pos = '{l[4:0], 16'(rem - row * longint'(cols_of[l])), row[15:0], 1'b0};
                    break;
                end
                rem -= area;
            end
            expected_pos.push_back(pos);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch on %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        task check_result(tile_pos_t got);
            tile_pos_t want;
            if (expected_pos.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = expected_pos.pop_front();
            if (got.level_found !== want.level_found)
                report_mismatch("level_found", got.level_found, want.level_found);
            if (got.tile_column !== want.tile_column)
                report_mismatch("tile_column", got.tile_column, want.tile_column);
            if (got.tile_row !== want.tile_row)
                report_mismatch("tile_row", got.tile_row, want.tile_row);
            if (got.out_of_range !== want.out_of_range)
                report_mismatch("out_of_range", got.out_of_range, want.out_of_range);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [ptim_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ptim_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    ptim_req_if req ();
    ptim_rsp_if rsp ();

    tile_map_scoreboard board = new();

    // when set, both sides run without gaps for a while
    bit no_idle = 1'b0;

    pyramid_tile_index_mapper_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.sink),
        .rsp      (rsp.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req.valid = 1'b0;
        req.command = ptim_pkg::CMD_LOAD;
        req.level_select = '0;
        req.level_width = '0;
        req.level_height = '0;
        req.linear_tile = '0;
        rsp.ready = 1'b0;
    end

    // register write, only while the block is idle
    task write_reg(logic [ptim_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one request transaction: optional gap, then hold valid until accepted
    task send_item(logic cmd, logic [4:0] sel, logic [15:0] w, logic [15:0] h, logic [31:0] tile);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 14));
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid = 1'b1;
        req.command = cmd;
        req.level_select = sel;
        req.level_width = w;
        req.level_height = h;
        req.linear_tile = tile;
        do @(posedge clk); while (!req.ready);
        board.note_input(cmd, sel, w, h, tile);
        @(negedge clk);
    endtask

    function logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1, 100));
        endcase
    endfunction

    task load_level(logic [4:0] sel);
        send_item(ptim_pkg::CMD_LOAD, sel, pick_size(), pick_size(), $urandom);
    endtask

    // query numbers mostly inside the pyramid, plus its edges and full-range noise
    task send_query();
        longint total;
        logic [31:0] tile;
        total = board.total_tiles();
        if (total > 64'hFFFF_FFFF)
            total = 64'hFFFF_FFFF;
        case ($urandom_range(0, 9))
            7: tile = (total > 0) ? 32'(total - 1) : 32'd0;
            8: tile = 32'(total);
            9: tile = $urandom;
            default: tile = (total > 0) ? 32'({$urandom, $urandom} % total) : $urandom;
        endcase
        send_item(ptim_pkg::CMD_QUERY, 5'($urandom), 16'($urandom), 16'($urandom), tile);
    endtask

    // let in-flight results and trailing loads drain before touching registers
    task wait_idle();
        req.valid = 1'b0;
        while (board.expected_pos.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    // one setting: registers, a full table load, then queries with some reloads
    task run_phase(logic [15:0] tw, logic [15:0] th, logic [5:0] lc, int queries);
        wait_idle();
        write_reg(ptim_pkg::REG_TILE_WIDTH, tw);
        write_reg(ptim_pkg::REG_TILE_HEIGHT, th);
        write_reg(ptim_pkg::REG_LEVEL_COUNT, {10'd0, lc});
        for (int l = 0; l < 32; l++)
            load_level(l[4:0]);
        for (int q = 0; q < queries; q++)
        begin
            if (q % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                load_level(5'($urandom));
            else
                send_query();
        end
        no_idle = 1'b0;
    endtask

    // response side: random stalls, results sampled at the rising edge
    initial
    begin
        tile_pos_t got;
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = no_idle ? 0 : int'($urandom_range(0, 14));
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready = 1'b1;
            do @(posedge clk); while (!rsp.valid);
            got = '{rsp.level_found, rsp.tile_column, rsp.tile_row, rsp.out_of_range};
            board.check_result(got);
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no levels in use: every number is out of range, and no table entry is read
        send_item(ptim_pkg::CMD_QUERY, 5'd0, 16'd0, 16'd0, 32'd0);
        send_item(ptim_pkg::CMD_QUERY, 5'd31, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);

        // extremes: unit, huge and zero tiles, level count above the table, and plain ones
        run_phase(16'd16, 16'd16, 6'd32, 20);
        run_phase(16'd1, 16'd1, 6'd32, 40);
        run_phase(16'hFFFF, 16'hFFFF, 6'd32, 100);
        run_phase(16'd0, 16'd0, 6'd63, 150);
        run_phase(16'd7, 16'd3, 6'd5, 150);
        run_phase(16'd1, 16'd16, 6'd1, 100);
        run_phase(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)), 6'd40, 150);
        run_phase(16'($urandom), 16'($urandom), 6'($urandom_range(0, 32)), 100);
        run_phase(16'($urandom_range(1, 32)), 16'($urandom_range(1, 32)),
                  6'($urandom_range(1, 32)), 150);

        wait_idle();
        if (board.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
